// ===== sv/rfd_pkg.sv =====
// shared types and constants for the remote frame decoder
package rfd_pkg;

  localparam int unsigned FRAME_BYTES = 16;
  localparam int unsigned CNT_W       = 5;

  localparam logic [7:0] HOLD_RESET = 8'd40;

  // switch positions that select a mode
  localparam logic [1:0] SW_UP  = 2'd1;
  localparam logic [1:0] SW_MID = 2'd3;

  localparam logic [1:0] MODE_FIRST  = 2'd0;
  localparam logic [1:0] MODE_SECOND = 2'd1;
  localparam logic [1:0] MODE_OTHER  = 2'd2;

  typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

  typedef struct packed {
    logic [43:0]        stick_channels;
    logic [3:0]         switch_pair;
    logic signed [15:0] mouse_x;
    logic signed [15:0] mouse_y;
    logic signed [15:0] mouse_z;
    logic [15:0]        mouse_buttons;
    logic [15:0]        key_bits;
    logic [1:0]         input_mode;
    logic [1:0]         function_mode;
    logic [3:0]         recent_two_code;
    logic [5:0]         recent_three_code;
    logic [1:0]         held_switch;
  } result_t;

  function automatic logic [1:0] mode_of(input logic [1:0] sw);
    logic [1:0] m;
    unique case (sw)
      SW_UP:   m = MODE_FIRST;
      SW_MID:  m = MODE_SECOND;
      default: m = MODE_OTHER;
    endcase
    return m;
  endfunction

endpackage

// ===== sv/rfd_fifo.sv =====
// small register queue used between the stages and at the output
module rfd_fifo import rfd_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0]    mem_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                do_wr, do_rd;

  assign full    = (cnt_r == CNT_BITS'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== sv/rfd_front.sv =====
// front end: gathers frame bytes and hands a complete frame on the last word
module rfd_front import rfd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_vld,
  input  logic [7:0] rx_byte,
  input  logic       frame_last,
  output logic       frame_push,
  output frame_t     frame_data
);

  frame_t           store_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             room;

  assign room       = (cnt_r < CNT_W'(FRAME_BYTES));
  assign frame_push = byte_vld && frame_last;

  // the last word goes straight into the frame handed on while there is room
  always_comb begin
    frame_data = store_r;
    if (room) begin
      frame_data[cnt_r[CNT_W-2:0]] = rx_byte;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (byte_vld) begin
      if (frame_last) begin
        cnt_nxt = '0;
      end else if (room) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_vld && room) begin
      store_r[cnt_r[CNT_W-2:0]] <= rx_byte;
    end
  end

endmodule

// ===== sv/rfd_back.sv =====
// back end: field decode and left switch history per frame
module rfd_back import rfd_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 3
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       frame_vld,
  input  frame_t     frame_data,
  input  logic       res_room,
  output logic       frame_take,
  output logic       res_push,
  output result_t    res,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  localparam int unsigned TAP_N = HISTORY_DEPTH - 1;

  logic [1:0] hist_r [TAP_N];
  logic       first_r;
  logic [7:0] same_cnt_r, same_cnt_nxt;
  logic [1:0] held_r, held_nxt;
  logic [7:0] hold_frames_r;

  logic [1:0] s1, s2, prev;
  logic [7:0] d [FRAME_BYTES];

  assign frame_take = frame_vld && res_room;
  assign res_push   = frame_take;

  always_comb begin
    for (int i = 0; i < FRAME_BYTES; i++) begin
      d[i] = frame_data[i];
    end
  end

  assign s1 = d[5][7:6];
  assign s2 = d[5][5:4];
  // on the very first frame the history compares with itself
  assign prev = first_r ? s1 : hist_r[0];

  always_comb begin
    same_cnt_nxt = 8'd0;
    if (s1 == prev) begin
      same_cnt_nxt = (same_cnt_r == 8'hFF) ? same_cnt_r : same_cnt_r + 8'd1;
    end
    held_nxt = (same_cnt_nxt >= hold_frames_r) ? s1 : held_r;
  end

  always_comb begin
    res.stick_channels    = {d[5][3:0], d[4][7:1],
                             d[4][0], d[3], d[2][7:6],
                             d[2][5:0], d[1][7:3],
                             d[1][2:0], d[0]};
    res.switch_pair       = {s1, s2};
    res.mouse_x           = {d[7], d[6]};
    res.mouse_y           = {d[9], d[8]};
    res.mouse_z           = {d[11], d[10]};
    res.mouse_buttons     = {d[13], d[12]};
    res.key_bits          = {d[15], d[14]};
    res.input_mode        = mode_of(s2);
    res.function_mode     = mode_of(s1);
    res.recent_two_code   = {prev, s1};
    res.recent_three_code = {hist_r[TAP_N-1], prev, s1};
    res.held_switch       = held_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAP_N; i++) begin
        hist_r[i] <= 2'd0;
      end
      first_r       <= 1'b1;
      same_cnt_r    <= 8'd0;
      held_r        <= 2'd0;
      hold_frames_r <= HOLD_RESET;
    end else begin
      if (cfg_wr_en) begin
        hold_frames_r <= cfg_wr_data;
      end
      if (frame_take) begin
        hist_r[0] <= s1;
        for (int i = 1; i < TAP_N; i++) begin
          hist_r[i] <= hist_r[i-1];
        end
        first_r    <= 1'b0;
        same_cnt_r <= same_cnt_nxt;
        held_r     <= held_nxt;
      end
    end
  end

endmodule

// ===== sv/remote_frame_decoder_top.sv =====
// remote frame decoder top level: byte front end, frame queue, decoder, result queue
//
//  channel  | ports                                  | handshake
//  ---------+----------------------------------------+------------------------------
//  input    | in_rx_byte, in_frame_last              | push && !full takes a word
//  result   | out_* fields                           | !empty shows, pop takes it
//  config   | cfg_wr_data                            | cfg_wr_en writes hold_frames
//
// one input word per cycle while full is low; a frame's last word goes into a
// two-entry frame queue; the decoder moves it on once the result queue has room.
// full follows the frame queue, so input stalls only when two frames wait in
// the frame queue behind a full result queue. the result queue holds two words.
// reset is synchronous and clears counters, history and both queues.
module remote_frame_decoder_top import rfd_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         in_rx_byte,
  input  logic               in_frame_last,
  input  logic               push,
  output logic               full,
  output logic [43:0]        out_stick_channels,
  output logic [3:0]         out_switch_pair,
  output logic signed [15:0] out_mouse_x,
  output logic signed [15:0] out_mouse_y,
  output logic signed [15:0] out_mouse_z,
  output logic [15:0]        out_mouse_buttons,
  output logic [15:0]        out_key_bits,
  output logic [1:0]         out_input_mode,
  output logic [1:0]         out_function_mode,
  output logic [3:0]         out_recent_two_code,
  output logic [5:0]         out_recent_three_code,
  output logic [1:0]         out_held_switch,
  output logic               empty,
  input  logic               pop,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data
);

  logic    byte_vld;
  logic    frame_push;
  frame_t  frame_in, frame_head;
  logic    mid_empty, mid_full;
  logic    frame_take;
  logic    res_push, res_full;
  result_t res_in, res_head;

  assign full     = mid_full;
  assign byte_vld = push && !mid_full;

  rfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_vld   (byte_vld),
    .rx_byte    (in_rx_byte),
    .frame_last (in_frame_last),
    .frame_push (frame_push),
    .frame_data (frame_in)
  );

  rfd_fifo #(
    .WIDTH ($bits(frame_t)),
    .DEPTH (2)
  ) u_frame_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (frame_push),
    .wr_data (frame_in),
    .rd_en   (frame_take),
    .rd_data (frame_head),
    .full    (mid_full),
    .empty   (mid_empty)
  );

  rfd_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_vld   (!mid_empty),
    .frame_data  (frame_head),
    .res_room    (!res_full),
    .frame_take  (frame_take),
    .res_push    (res_push),
    .res         (res_in),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  rfd_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_in),
    .rd_en   (pop),
    .rd_data (res_head),
    .full    (res_full),
    .empty   (empty)
  );

  assign out_stick_channels    = res_head.stick_channels;
  assign out_switch_pair       = res_head.switch_pair;
  assign out_mouse_x           = res_head.mouse_x;
  assign out_mouse_y           = res_head.mouse_y;
  assign out_mouse_z           = res_head.mouse_z;
  assign out_mouse_buttons     = res_head.mouse_buttons;
  assign out_key_bits          = res_head.key_bits;
  assign out_input_mode        = res_head.input_mode;
  assign out_function_mode     = res_head.function_mode;
  assign out_recent_two_code   = res_head.recent_two_code;
  assign out_recent_three_code = res_head.recent_three_code;
  assign out_held_switch       = res_head.held_switch;

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench for the remote frame decoder top level
`timescale 1ns / 1ps

module tb_top;
  import rfd_pkg::*;

  localparam int unsigned HIST_DEPTH  = 3;
  localparam int unsigned LONG_STALL  = 150;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } rx_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [7:0] in_rx_byte = '0;
  logic in_frame_last = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [43:0] out_stick_channels;
  logic [3:0] out_switch_pair;
  logic signed [15:0] out_mouse_x;
  logic signed [15:0] out_mouse_y;
  logic signed [15:0] out_mouse_z;
  logic [15:0] out_mouse_buttons;
  logic [15:0] out_key_bits;
  logic [1:0] out_input_mode;
  logic [1:0] out_function_mode;
  logic [3:0] out_recent_two_code;
  logic [5:0] out_recent_three_code;
  logic [1:0] out_held_switch;
  logic empty;
  logic pop = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = '0;

  // words waiting to be sent, and decoded frames waiting to come out
  rx_word_t tx_words[$];
  result_t expected_frames[$];

  // decoder shadow state
  logic [7:0] rx_store[FRAME_BYTES];
  int unsigned fill_count = 0;
  logic [1:0] s1_hist[HIST_DEPTH];
  int unsigned wr_slot = 0;
  int unsigned prev_slot = 0;
  logic [7:0] run_count = '0;
  logic [1:0] held_sw = '0;
  logic [7:0] hold_cfg = HOLD_RESET;

  int unsigned fail_count = 0;
  int unsigned report_count = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles = 0;
  logic [1:0] sticky_s1 = '0;

  // sender and receiver pacing
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned next_stall_at = 10;
  logic [7:0] pop_pattern = '1;
  logic [2:0] pat_idx = '0;

  remote_frame_decoder_top #(
    .HISTORY_DEPTH(HIST_DEPTH)
  ) u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_rx_byte           (in_rx_byte),
    .in_frame_last        (in_frame_last),
    .push                 (push),
    .full                 (full),
    .out_stick_channels   (out_stick_channels),
    .out_switch_pair      (out_switch_pair),
    .out_mouse_x          (out_mouse_x),
    .out_mouse_y          (out_mouse_y),
    .out_mouse_z          (out_mouse_z),
    .out_mouse_buttons    (out_mouse_buttons),
    .out_key_bits         (out_key_bits),
    .out_input_mode       (out_input_mode),
    .out_function_mode    (out_function_mode),
    .out_recent_two_code  (out_recent_two_code),
    .out_recent_three_code(out_recent_three_code),
    .out_held_switch      (out_held_switch),
    .empty                (empty),
    .pop                  (pop),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [1:0] mode_for(input logic [1:0] sw);
    if (sw == SW_UP) return MODE_FIRST;
    if (sw == SW_MID) return MODE_SECOND;
    return MODE_OTHER;
  endfunction

  // stores one word and, on the last word of a frame, decodes the store
  task automatic track_rx_word(input logic [7:0] b, input logic last);
    result_t r;
    logic [23:0] w;
    logic [10:0] c0, c1, c2, c3;
    logic [1:0] s1, s2;
    int unsigned nxt;
    if (fill_count < FRAME_BYTES) begin
      rx_store[fill_count] = b;
      fill_count++;
    end
    if (last) begin
      fill_count = 0;
      w = {rx_store[1], rx_store[0]};
      c0 = w[10:0];
      w = {rx_store[2], rx_store[1]} >> 3;
      c1 = w[10:0];
      w = {rx_store[4], rx_store[3], rx_store[2]} >> 6;
      c2 = w[10:0];
      w = {rx_store[5], rx_store[4]} >> 1;
      c3 = w[10:0];
      s1 = rx_store[5][7:6];
      s2 = rx_store[5][5:4];
      nxt = (wr_slot + 1) % HIST_DEPTH;
      s1_hist[wr_slot] = s1;
      r.stick_channels = {c3, c2, c1, c0};
      r.switch_pair = {s1, s2};
      r.mouse_x = {rx_store[7], rx_store[6]};
      r.mouse_y = {rx_store[9], rx_store[8]};
      r.mouse_z = {rx_store[11], rx_store[10]};
      r.mouse_buttons = {rx_store[13], rx_store[12]};
      r.key_bits = {rx_store[15], rx_store[14]};
      r.input_mode = mode_for(s2);
      r.function_mode = mode_for(s1);
      r.recent_two_code = {s1_hist[prev_slot], s1};
      r.recent_three_code = {s1_hist[nxt], r.recent_two_code};
      // first frame after reset compares the slot with itself
      if (s1 == s1_hist[prev_slot]) begin
        if (run_count != 8'hFF) run_count = run_count + 8'd1;
      end else begin
        run_count = '0;
      end
      if (run_count >= hold_cfg) held_sw = s1;
      r.held_switch = held_sw;
      prev_slot = wr_slot;
      wr_slot = nxt;
      expected_frames.push_back(r);
    end
  endtask

  function automatic void check_field(input string fname, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      fail_count++;
      if (report_count < MAX_REPORTS)
        $display("mismatch on %s: expected %0h, got %0h", fname, want, got);
      report_count++;
    end
  endfunction

  // sender: bursts of random length, random gaps between them
  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (gap_left != 0) begin
      push <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (tx_words.size() != 0) begin
      push <= 1'b1;
      in_rx_byte <= tx_words[0].b;
      in_frame_last <= tx_words[0].last;
      if (burst_left == 0) begin
        burst_left <= $urandom_range(1, 40);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      push <= 1'b0;
    end
  end

  // receiver: stall pattern of its own, plus long hold-offs so the block backs up
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
      stall_left <= 0;
      next_stall_at <= 10;
    end else if (stall_left != 0) begin
      pop <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (results_seen >= next_stall_at) begin
      pop <= 1'b0;
      stall_left <= LONG_STALL;
      next_stall_at <= next_stall_at + 150;
    end else begin
      pop <= pop_pattern[pat_idx];
      pat_idx <= pat_idx + 3'd1;
      if (pat_idx == 3'd7)
        pop_pattern <= ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
    end
  end

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst_n) begin
      if ((push && !full) || (pop && !empty) || cfg_wr_en)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
      if (push && !full) begin
        track_rx_word(in_rx_byte, in_frame_last);
        void'(tx_words.pop_front());
      end
      if (pop && !empty) begin
        results_seen++;
        if (expected_frames.size() == 0) begin
          fail_count++;
          if (report_count < MAX_REPORTS)
            $display("result word with nothing expected, sticks %0h", out_stick_channels);
          report_count++;
        end else begin
          want = expected_frames.pop_front();
          check_field("stick_channels", want.stick_channels, out_stick_channels);
          check_field("switch_pair", want.switch_pair, out_switch_pair);
          check_field("mouse_x", $unsigned(want.mouse_x), $unsigned(out_mouse_x));
          check_field("mouse_y", $unsigned(want.mouse_y), $unsigned(out_mouse_y));
          check_field("mouse_z", $unsigned(want.mouse_z), $unsigned(out_mouse_z));
          check_field("mouse_buttons", want.mouse_buttons, out_mouse_buttons);
          check_field("key_bits", want.key_bits, out_key_bits);
          check_field("input_mode", want.input_mode, out_input_mode);
          check_field("function_mode", want.function_mode, out_function_mode);
          check_field("recent_two_code", want.recent_two_code, out_recent_two_code);
          check_field("recent_three_code", want.recent_three_code, out_recent_three_code);
          check_field("held_switch", want.held_switch, out_held_switch);
        end
      end
    end
  end

  task automatic queue_frame(input int unsigned len);
    rx_word_t w;
    for (int unsigned i = 0; i < len; i++) begin
      w.b = 8'($urandom);
      // left switch mostly repeats so the hold logic gets exercised
      if (i == 5) begin
        if ($urandom_range(0, 3) == 0) sticky_s1 = 2'($urandom);
        w.b[7:6] = sticky_s1;
      end
      w.last = (i == len - 1);
      tx_words.push_back(w);
    end
  endtask

  task automatic queue_random_frames(input int unsigned n_words);
    int unsigned sent;
    int unsigned k;
    sent = 0;
    while (sent < n_words) begin
      k = $urandom_range(0, 9);
      if (k < 6) begin
        queue_frame((k % 2) ? 18 : 16);
        sent += (k % 2) ? 18 : 16;
      end else if (k < 8) begin
        k = $urandom_range(1, 15);
        queue_frame(k);
        sent += k;
      end else begin
        k = $urandom_range(17, 24);
        queue_frame(k);
        sent += k;
      end
    end
  endtask

  task automatic drain_all();
    while (tx_words.size() != 0 || expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_hold(input logic [7:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    hold_cfg = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    rx_word_t w;
    for (int i = 0; i < FRAME_BYTES; i++) rx_store[i] = '0;
    for (int i = 0; i < HIST_DEPTH; i++) s1_hist[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full frame of all ones first, so every store entry has been written
    for (int i = 0; i < 16; i++) begin
      w.b = 8'hFF;
      w.last = (i == 15);
      tx_words.push_back(w);
    end
    // short frame of zeros: later bytes keep the older values
    for (int i = 0; i < 6; i++) begin
      w.b = 8'h00;
      w.last = (i == 5);
      tx_words.push_back(w);
    end
    w.b = 8'h00;
    w.last = 1'b1;
    tx_words.push_back(w);
    queue_random_frames(110);
    drain_all();

    write_hold(8'd1);
    queue_random_frames(100);
    drain_all();

    // one-word frames leave the switch byte alone, so the run counter saturates
    write_hold(8'd255);
    for (int i = 0; i < 270; i++) begin
      w.b = 8'($urandom);
      w.last = 1'b1;
      tx_words.push_back(w);
    end
    queue_random_frames(30);
    drain_all();

    // hold of zero: held value tracks the switch every frame
    write_hold(8'd0);
    queue_random_frames(60);
    drain_all();

    write_hold(8'($urandom_range(2, 6)));
    queue_random_frames(60);
    drain_all();

    fail_count += expected_frames.size();
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
